// ----- rtl/cgbl_pkg.sv -----
package cgbl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_R,
    ST_DIV_I,
    ST_EDGE,
    ST_PROBE,
    ST_CORNER,
    ST_WSET,
    ST_WDIV,
    ST_LERP,
    ST_FINISH
  } cgbl_state_e;

  typedef enum logic [1:0] {
    W_ZERO,
    W_ONE,
    W_DIV
  } cgbl_wsel_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BELOW = 2'd1;
  localparam logic [1:0] STATUS_ERR   = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_NR = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NI = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LI = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HR = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HI = 3'd5;

  localparam int CountW = 13;
  localparam int DataW  = 32;

  typedef struct packed {
    logic start;
    logic done;
  } cgbl_div_ctl_t;

endpackage

// ----- rtl/cgbl_ram.sv -----
module cgbl_ram #(
  parameter int Width = 128,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/cgbl_div.sv -----
module cgbl_div #(
  parameter int DvdW = 59,
  parameter int QuotW = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DvdW-1:0]  dividend_i,
  input  logic [DvdW-1:0]  divisor_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int CntW = $clog2(QuotW + 1);

  logic [DvdW-1:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             ge;

  assign ge = rem_q >= dsr_q;

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsr_d  = divisor_i << (QuotW - 1);
      quot_d = '0;
      cnt_d  = CntW'(QuotW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? rem_q - dsr_q : rem_q;
      quot_d = {quot_q[QuotW-2:0], ge};
      dsr_d  = dsr_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/cgbl_lerp.sv -----
module cgbl_lerp #(
  parameter int WeightW = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic [WeightW-1:0] t_i,
  output logic               valid_o,
  output logic signed [31:0] r_o
);

  localparam int Frac = WeightW - 1;
  localparam int ProdW = WeightW + 33;
  localparam logic [WeightW-1:0] One = WeightW'(1) << Frac;

  logic signed [ProdW-1:0] pa_q, pa_d, pb_q, pb_d;
  logic signed [ProdW:0]   sum, sh;
  logic [WeightW-1:0]      omt;
  logic [ProdW-31:0]       top;
  logic signed [31:0]      r_q, r_d;
  logic                    v1_q, v2_q;

  assign omt  = One - t_i;
  assign pa_d = ProdW'($signed({1'b0, omt})) * ProdW'(a_i);
  assign pb_d = ProdW'($signed({1'b0, t_i})) * ProdW'(b_i);

  assign sum = (ProdW+1)'(pa_q) + (ProdW+1)'(pb_q) + (ProdW+1)'($signed({1'b0, One >> 1}));
  assign sh  = sum >>> Frac;
  assign top = sh[ProdW:31];

  always_comb begin
    if ((&top) || !(|top)) begin
      r_d = sh[31:0];
    end else if (sh[ProdW]) begin
      r_d = {1'b1, 31'd0};
    end else begin
      r_d = {1'b0, {31{1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;
    pb_q <= pb_d;
    r_q  <= r_d;
  end

  assign valid_o = v2_q;
  assign r_o     = r_q;

endmodule

// ----- rtl/complex_grid_bilinear_lut_core.sv -----
// Bilinear lookup over a table of complex grid points (Q8.24 by default).
// Input channel (in_valid_i/in_ready_o): action 0 writes one table entry
// (coordinate and value), action 1 queries a point. A write completes in the
// transaction cycle and gives no result. A query gives one result on the
// output channel (out_valid_o/out_ready_i) with a status code.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user
// must write it only while no query is in flight, as the block does not enforce it.
// A point outside the grid finishes after the range check, and one on an edge
// cell (nonzero imaginary part) after the grid index divisions. Otherwise a query
// runs the index divisions, five reads of the single table memory, the weight
// divisions (none for a weight that is 0 or 1) and the interpolation pipeline in
// three steps. All four divisions use the shared bit-per-cycle divider, QB
// quotient bits each, QB = max(13, FRACTION_BITS+1), 25 at the defaults.
// One query is in work at a time; the next transaction is taken once the
// result is in the output register, even while it waits to be taken.
// A stalled receiver holds the result; a finished query then waits for it.
// Reset clears control state and loads the default grid configuration; the
// table contents are undefined until written.
module complex_grid_bilinear_lut_core #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cgbl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [11:0]                   entry_index_i,
  input  logic signed [31:0]            point_real_i,
  input  logic signed [31:0]            point_imag_i,
  input  logic signed [31:0]            entry_value_real_i,
  input  logic signed [31:0]            entry_value_imag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            result_real_o,
  output logic signed [31:0]            result_imag_o,
  output logic [1:0]                    status_o
);

  import cgbl_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int WT   = FRACTION_BITS + 1;
  localparam int QB   = (WT > CountW) ? WT : CountW;
  localparam int DvdW = 34 + QB;
  localparam logic [WT-1:0] One = WT'(1) << FRACTION_BITS;

  // configuration
  logic [CountW-1:0]  nr_q, ni_q, nr_e, ni_e;
  logic signed [31:0] lr_q, li_q, hr_q, hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q <= CountW'(64);
      ni_q <= CountW'(64);
      lr_q <= '0;
      li_q <= '0;
      hr_q <= '0;
      hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NR:  nr_q <= cfg_data_i[CountW-1:0];
        CFG_NI:  ni_q <= cfg_data_i[CountW-1:0];
        CFG_LR:  lr_q <= cfg_data_i;
        CFG_LI:  li_q <= cfg_data_i;
        CFG_HR:  hr_q <= cfg_data_i;
        CFG_HI:  hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr_e = (nr_q == '0) ? CountW'(1) : nr_q;
  assign ni_e = (ni_q == '0) ? CountW'(1) : ni_q;

  cgbl_state_e state_q, state_d;

  logic signed [31:0]       sr_q, si_q;
  logic                     spec_r_q, spec_i_q;
  logic [CountW-1:0]        r_q, i_q;
  logic signed [CountW:0]   r0_q, i0_q;
  logic [2:0]               k_q;
  logic [63:0]              c0_q, c3_q;
  logic [63:0]              v_q [4];
  logic                     w_axis_q;
  cgbl_wsel_e               wsel_q, wsel;
  logic [WT-1:0]            tx_q, ty_q, tval;
  logic [1:0]               lstep_q;
  logic                     lgo_q;
  logic signed [31:0]       p_re_q [2];
  logic signed [31:0]       p_im_q [2];
  logic signed [31:0]       fin_re_q, fin_im_q;
  logic [1:0]               fin_st_q;
  logic                     out_valid_q;
  logic signed [31:0]       res_re_q, res_im_q;
  logic [1:0]               res_st_q;

  logic acc_in;
  assign in_ready_o = (state_q == ST_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;

  // range check
  logic               oob, si_zero, edge_err;
  logic [1:0]         oob_st;
  logic signed [32:0] off_r, span_r, off_i, span_i;
  logic               spec_r, spec_i;

  assign oob     = (sr_q < lr_q) || (sr_q > hr_q) || (si_q < hi_q) || (si_q > li_q);
  assign si_zero = (si_q == '0);
  assign oob_st  = (si_zero && (sr_q < lr_q)) ? STATUS_BELOW : STATUS_ERR;
  assign off_r   = 33'(sr_q) - 33'(lr_q);
  assign span_r  = 33'(hr_q) - 33'(lr_q);
  assign off_i   = 33'(li_q) - 33'(si_q);
  assign span_i  = 33'(li_q) - 33'(hi_q);
  assign spec_r  = (nr_e <= CountW'(1)) || (span_r <= 0) || (off_r <= 0);
  assign spec_i  = (ni_e <= CountW'(1)) || (span_i <= 0) || (off_i <= 0);
  assign edge_err = !si_zero && ((i_q == '0) || (i_q == ni_e - 1'b1) ||
                                 (r_q == '0) || (r_q == nr_e - 1'b1));

  // divider operands
  logic               sel_r;
  logic [31:0]        idx_off, idx_span;
  logic [CountW-1:0]  idx_nm1;
  logic [44:0]        idx_prod;
  logic [46:0]        idx_dvd;
  logic signed [33:0] wnum, wden, wn2, wd2;
  logic [DvdW-1:0]    w_dvd;
  cgbl_div_ctl_t      div_ctl;
  logic [DvdW-1:0]    div_dvd, div_dsr;
  logic [QB-1:0]      div_q;

  assign sel_r    = (state_q == ST_CHECK);
  assign idx_off  = sel_r ? off_r[31:0] : off_i[31:0];
  assign idx_span = sel_r ? span_r[31:0] : span_i[31:0];
  assign idx_nm1  = (sel_r ? nr_e : ni_e) - 1'b1;
  assign idx_prod = 45'(idx_off) * 45'(idx_nm1);
  assign idx_dvd  = {idx_prod, 1'b0} + 47'(idx_span);

  assign wnum = w_axis_q ? 34'(si_q) - 34'($signed(c0_q[63:32]))
                         : 34'(sr_q) - 34'($signed(c0_q[31:0]));
  assign wden = w_axis_q ? 34'($signed(c3_q[63:32])) - 34'($signed(c0_q[63:32]))
                         : 34'($signed(c3_q[31:0])) - 34'($signed(c0_q[31:0]));
  assign wn2  = wden[33] ? -wnum : wnum;
  assign wd2  = wden[33] ? -wden : wden;

  always_comb begin
    if (wden == '0 || wn2 <= 0) begin
      wsel = W_ZERO;
    end else if (wn2 >= wd2) begin
      wsel = W_ONE;
    end else begin
      wsel = W_DIV;
    end
  end

  assign w_dvd = (DvdW'(wn2[31:0]) << WT) + DvdW'(wd2[31:0]);

  always_comb begin
    div_ctl.start = 1'b0;
    div_dvd       = DvdW'(idx_dvd);
    div_dsr       = DvdW'({idx_span, 1'b0});
    case (state_q)
      ST_CHECK: div_ctl.start = !oob;
      ST_DIV_R: div_ctl.start = div_ctl.done;
      ST_WSET: begin
        div_ctl.start = (wsel == W_DIV);
        div_dvd       = w_dvd;
        div_dsr       = DvdW'({wd2[31:0], 1'b0});
      end
      default: ;
    endcase
  end

  cgbl_div #(
    .DvdW  (DvdW),
    .QuotW (QB)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_ctl.start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_ctl.done),
    .quot_o     (div_q)
  );

  always_comb begin
    case (wsel_q)
      W_ZERO:  tval = '0;
      W_ONE:   tval = One;
      default: tval = div_q[WT-1:0];
    endcase
  end

  // table memory
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [127:0]           ram_wdata, ram_rdata;
  logic signed [CountW:0] rr, ii;
  logic signed [27:0]     lin;

  assign ram_we    = acc_in && (action_i == ACT_WRITE);
  assign ram_waddr = AW'(entry_index_i);
  assign ram_wdata = {entry_value_imag_i, entry_value_real_i, point_imag_i, point_real_i};

  always_comb begin
    if (state_q == ST_CORNER) begin
      rr = r0_q + (CountW+1)'(k_q[0]);
      ii = i0_q + (CountW+1)'(k_q[1]);
    end else begin
      rr = $signed({1'b0, r_q});
      ii = $signed({1'b0, i_q});
    end
  end

  assign lin       = 28'($signed({1'b0, ni_e})) * 28'(rr) + 28'(ii);
  assign ram_raddr = lin[AW-1:0];

  cgbl_ram #(
    .Width (128),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // interpolation lanes
  logic signed [31:0] la_re, lb_re, la_im, lb_im, lr_re, lr_im;
  logic [WT-1:0]      lt;
  logic               lv_re, lv_im;

  always_comb begin
    case (lstep_q)
      2'd0: begin
        la_re = v_q[0][31:0];  lb_re = v_q[1][31:0];
        la_im = v_q[0][63:32]; lb_im = v_q[1][63:32];
        lt    = tx_q;
      end
      2'd1: begin
        la_re = v_q[2][31:0];  lb_re = v_q[3][31:0];
        la_im = v_q[2][63:32]; lb_im = v_q[3][63:32];
        lt    = tx_q;
      end
      default: begin
        la_re = p_re_q[0]; lb_re = p_re_q[1];
        la_im = p_im_q[0]; lb_im = p_im_q[1];
        lt    = ty_q;
      end
    endcase
  end

  cgbl_lerp #(.WeightW (WT)) u_lerp_re (
    .clk_i, .rst_ni,
    .valid_i (lgo_q), .a_i (la_re), .b_i (lb_re), .t_i (lt),
    .valid_o (lv_re), .r_o (lr_re)
  );

  cgbl_lerp #(.WeightW (WT)) u_lerp_im (
    .clk_i, .rst_ni,
    .valid_i (lgo_q), .a_i (la_im), .b_i (lb_im), .t_i (lt),
    .valid_o (lv_im), .r_o (lr_im)
  );

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (acc_in && action_i == ACT_QUERY) state_d = ST_CHECK;
      ST_CHECK:  state_d = oob ? ST_FINISH : ST_DIV_R;
      ST_DIV_R:  if (div_ctl.done) state_d = ST_DIV_I;
      ST_DIV_I:  if (div_ctl.done) state_d = ST_EDGE;
      ST_EDGE:   state_d = edge_err ? ST_FINISH : ST_PROBE;
      ST_PROBE:  state_d = ST_CORNER;
      ST_CORNER: if (k_q == 3'd4) state_d = ST_WSET;
      ST_WSET:   state_d = ST_WDIV;
      ST_WDIV: begin
        if (wsel_q != W_DIV || div_ctl.done) begin
          state_d = w_axis_q ? ST_LERP : ST_WSET;
        end
      end
      ST_LERP:   if (lv_re && lstep_q == 2'd2) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lgo_q       <= 1'b0;
      k_q         <= '0;
      lstep_q     <= '0;
      w_axis_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_PROBE: begin
          k_q   <= '0;
          lgo_q <= 1'b0;
        end
        ST_CORNER: begin
          k_q      <= k_q + 1'b1;
          w_axis_q <= 1'b0;
          lgo_q    <= 1'b0;
        end
        ST_WDIV: begin
          lgo_q <= w_axis_q && (wsel_q != W_DIV || div_ctl.done);
          if (wsel_q != W_DIV || div_ctl.done) begin
            w_axis_q <= 1'b1;
            lstep_q  <= '0;
          end
        end
        ST_LERP: begin
          lgo_q <= lv_re && (lstep_q != 2'd2);
          if (lv_re && lstep_q != 2'd2) begin
            lstep_q <= lstep_q + 1'b1;
          end
        end
        default: lgo_q <= 1'b0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      sr_q <= point_real_i;
      si_q <= point_imag_i;
    end
    case (state_q)
      ST_CHECK: begin
        spec_r_q <= spec_r;
        spec_i_q <= spec_i;
        fin_st_q <= oob_st;
        fin_re_q <= '0;
        fin_im_q <= '0;
      end
      ST_DIV_R: if (div_ctl.done) r_q <= spec_r_q ? '0 : div_q[CountW-1:0];
      ST_DIV_I: if (div_ctl.done) i_q <= spec_i_q ? '0 : div_q[CountW-1:0];
      ST_EDGE:  fin_st_q <= edge_err ? STATUS_ERR : STATUS_OK;
      ST_PROBE: begin
        r0_q <= $signed({1'b0, r_q}) -
                (CountW+1)'($signed(ram_rdata[31:0]) > sr_q);
        i0_q <= $signed({1'b0, i_q}) -
                (CountW+1)'($signed(ram_rdata[63:32]) < si_q);
      end
      ST_CORNER: begin
        if (k_q != '0) begin
          v_q[k_q[1:0] - 2'd1] <= ram_rdata[127:64];
          if (k_q == 3'd1) c0_q <= ram_rdata[63:0];
          if (k_q == 3'd4) c3_q <= ram_rdata[63:0];
        end
      end
      ST_WSET: wsel_q <= wsel;
      ST_WDIV: begin
        if (wsel_q != W_DIV || div_ctl.done) begin
          if (w_axis_q) ty_q <= tval;
          else          tx_q <= tval;
        end
      end
      ST_LERP: begin
        if (lv_re) begin
          if (lstep_q == 2'd2) begin
            fin_re_q <= lr_re;
            fin_im_q <= lr_im;
          end else begin
            p_re_q[lstep_q[0]] <= lr_re;
            p_im_q[lstep_q[0]] <= lr_im;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          res_re_q <= fin_re_q;
          res_im_q <= fin_im_q;
          res_st_q <= fin_st_q;
        end
      end
      default: ;
    endcase
  end

  logic unused_lv;
  assign unused_lv = lv_im;

  assign out_valid_o   = out_valid_q;
  assign result_real_o = res_re_q;
  assign result_imag_o = res_im_q;
  assign status_o      = res_st_q;

endmodule
